[rtl/core/cce_pkg.sv]
// Shared types and constants for the contour cell segment extractor.
`default_nettype none

package cce_pkg;

   // Field widths
   localparam int SAMPLE_W  = 16;
   localparam int COL_W     = 14;
   localparam int ROW_W     = 16;
   localparam int COORD_W   = 16;
   localparam int SCALE_W   = 24;
   localparam int FRAC_W    = 16;
   localparam int POS_W     = 33;
   localparam int CSR_IDX_W = 2;

   // Contour level and the value a sample on the level is moved to
   localparam logic signed [17:0] LEVEL      = 18'sd256;
   localparam logic signed [17:0] LEVEL_BUMP = 18'sd257;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_X_ORIGIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_ORIGIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_SCALE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_SCALE  = 2'd3;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

   // Queue and pipeline sizes
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;
   localparam int OUT_DEPTH   = 32;
   localparam int OUT_PTR_W   = 5;
   localparam int CNT_W       = 6;
   localparam int DIV_STAGES  = 16;

   // One end point: integer grid corner plus an optional fraction on x and/or y
   typedef struct packed {
      logic [COL_W-1:0]  x_int;
      logic [ROW_W:0]    y_int;
      logic              x_frac;
      logic              x_neg;
      logic              y_frac;
      logic              y_neg;
      logic [FRAC_W-1:0] num;
      logic [FRAC_W-1:0] den;
   } point_type;

   typedef struct packed {
      point_type start_pt;
      point_type end_pt;
      logic      last;
   } seg_type;

   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] x_origin;
      logic [COORD_W-1:0] y_origin;
      logic [SCALE_W-1:0] x_scale;
      logic [SCALE_W-1:0] y_scale;
   } csr_type;

   typedef struct packed {
      logic [CNT_W-1:0] credits;
      logic [CNT_W-1:0] out_count;
   } back_status_type;

endpackage

`default_nettype wire

[rtl/core/contour_cell_segment_extractor_top.sv]
// Top level: register port, classifier, segment queue and arithmetic back end.
// Throughput: one cell per cycle while req_full is low; a cell that yields two
// segments raises req_full until its second one is queued. The back end retires
// one segment per cycle through two 16-stage dividers while segments and credits remain.
// Reset clears queues, counters and the result buffer; scales return to 1.0, origins to 0.
`default_nettype none

module contour_cell_segment_extractor_top #(
   parameter int unsigned ROW_LENGTH = 16384
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [cce_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [cce_pkg::SCALE_W-1:0]         csr_wdata,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic signed [cce_pkg::SAMPLE_W-1:0] req_lower_left_sample,
   input  wire logic signed [cce_pkg::SAMPLE_W-1:0] req_lower_right_sample,
   input  wire logic signed [cce_pkg::SAMPLE_W-1:0] req_upper_left_sample,
   input  wire logic signed [cce_pkg::SAMPLE_W-1:0] req_upper_right_sample,
   input  wire logic [cce_pkg::COL_W-1:0]           req_column,
   input  wire logic [cce_pkg::ROW_W-1:0]           req_row_index,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic [cce_pkg::COORD_W-1:0]              rsp_start_x,
   output logic [cce_pkg::COORD_W-1:0]              rsp_start_y,
   output logic [cce_pkg::COORD_W-1:0]              rsp_end_x,
   output logic [cce_pkg::COORD_W-1:0]              rsp_end_y,
   output logic                                     rsp_last_segment
);

   cce_pkg::csr_type          csr_ff;
   cce_pkg::seg_type          fq_wdata, fq_rdata;
   logic                      fq_push, fq_full, fq_pop, fq_empty;
   cce_pkg::rsp_type          rsp_data;
   cce_pkg::back_status_type  status;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.x_origin <= '0;
         csr_ff.y_origin <= '0;
         csr_ff.x_scale  <= cce_pkg::SCALE_RESET;
         csr_ff.y_scale  <= cce_pkg::SCALE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            cce_pkg::CSR_X_ORIGIN: csr_ff.x_origin <= csr_wdata[cce_pkg::COORD_W-1:0];
            cce_pkg::CSR_Y_ORIGIN: csr_ff.y_origin <= csr_wdata[cce_pkg::COORD_W-1:0];
            cce_pkg::CSR_X_SCALE:  csr_ff.x_scale  <= csr_wdata;
            cce_pkg::CSR_Y_SCALE:  csr_ff.y_scale  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   cce_front #(
      .ROW_LENGTH (ROW_LENGTH)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .lower_left_sample  (req_lower_left_sample),
      .lower_right_sample (req_lower_right_sample),
      .upper_left_sample  (req_upper_left_sample),
      .upper_right_sample (req_upper_right_sample),
      .column             (req_column),
      .row_index          (req_row_index),
      .q_push             (fq_push),
      .q_data             (fq_wdata),
      .q_full             (fq_full)
   );

   cce_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (fq_push),
      .wdata (fq_wdata),
      .full  (fq_full),
      .pop   (fq_pop),
      .rdata (fq_rdata),
      .empty (fq_empty)
   );

   cce_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (fq_empty),
      .q_data    (fq_rdata),
      .q_pop     (fq_pop),
      .csr       (csr_ff),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .status    (status)
   );

   assign rsp_start_x      = rsp_data.start_x;
   assign rsp_start_y      = rsp_data.start_y;
   assign rsp_end_x        = rsp_data.end_x;
   assign rsp_end_y        = rsp_data.end_y;
   assign rsp_last_segment = rsp_data.last;

   // Credits never exceed the result buffer depth
   assert property (@(posedge clock) disable iff (reset)
      status.credits <= cce_pkg::CNT_W'(cce_pkg::OUT_DEPTH))
      else $error("credit count beyond result buffer depth");

   // Buffered results are always covered by credits
   assert property (@(posedge clock) disable iff (reset)
      status.out_count <= status.credits)
      else $error("result buffer holds more than was issued");

   // Nothing waits at the result ports right after reset
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> rsp_empty)
      else $error("result present after reset");

endmodule

`default_nettype wire

[rtl/core/cce_queue.sv]
// Short segment queue between the classifier and the arithmetic back end.
`default_nettype none

module cce_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  cce_pkg::seg_type      wdata,
   output logic                  full,
   input  wire logic             pop,
   output cce_pkg::seg_type      rdata,
   output logic                  empty
);

   cce_pkg::seg_type                      mem_ff [cce_pkg::QUEUE_DEPTH];
   logic [cce_pkg::QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [cce_pkg::QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [cce_pkg::QUEUE_CNT_W-1:0]       cnt_ff, cnt_in;
   logic                                  do_push, do_pop;

   assign full    = (cnt_ff == cce_pkg::QUEUE_CNT_W'(cce_pkg::QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + {{(cce_pkg::QUEUE_CNT_W-1){1'b0}}, do_push}
                         - {{(cce_pkg::QUEUE_CNT_W-1){1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

[rtl/core/cce_front.sv]
// Cell classifier: decides which segments a cell yields and queues their end points.
`default_nettype none

module cce_front #(
   parameter int unsigned ROW_LENGTH = 16384
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic signed [cce_pkg::SAMPLE_W-1:0] lower_left_sample,
   input  wire logic signed [cce_pkg::SAMPLE_W-1:0] lower_right_sample,
   input  wire logic signed [cce_pkg::SAMPLE_W-1:0] upper_left_sample,
   input  wire logic signed [cce_pkg::SAMPLE_W-1:0] upper_right_sample,
   input  wire logic [cce_pkg::COL_W-1:0]           column,
   input  wire logic [cce_pkg::ROW_W-1:0]           row_index,
   output logic                                     q_push,
   output cce_pkg::seg_type                         q_data,
   input  wire logic                                q_full
);

   // Build an end point with its interpolation operands (a below, b above the level)
   function automatic cce_pkg::point_type make_pt(
      input logic [cce_pkg::COL_W-1:0] xi,
      input logic [cce_pkg::ROW_W:0]   yi,
      input logic                      xf,
      input logic                      xn,
      input logic                      yf,
      input logic                      yn,
      input logic signed [17:0]        a,
      input logic signed [17:0]        b
   );
      cce_pkg::point_type p;
      logic signed [17:0] nm;
      logic signed [17:0] dn;
      nm       = cce_pkg::LEVEL - a;
      dn       = b - a;
      p.x_int  = xi;
      p.y_int  = yi;
      p.x_frac = xf;
      p.x_neg  = xn;
      p.y_frac = yf;
      p.y_neg  = yn;
      p.num    = nm[cce_pkg::FRAC_W-1:0];
      p.den    = dn[cce_pkg::FRAC_W-1:0];
      return p;
   endfunction

   function automatic logic signed [17:0] bump(input logic signed [cce_pkg::SAMPLE_W-1:0] s);
      logic signed [17:0] v;
      v = 18'(s);
      return (v == cce_pkg::LEVEL) ? cce_pkg::LEVEL_BUMP : v;
   endfunction

   logic signed [17:0]          v0, v1, v2, v3;
   logic [3:0]                  lt;
   logic                        col_ok, all_below;
   logic [cce_pkg::COL_W-1:0]   xl, xr;
   logic [cce_pkg::ROW_W:0]     yb, yt;
   cce_pkg::point_type          pd, ps, pe;
   cce_pkg::seg_type            opt0, opt1, seg0, seg1;
   logic                        have0, have1;
   logic [1:0]                  n_seg;
   logic                        accept;
   cce_pkg::seg_type            hold_ff;
   logic                        hold_vld_ff, hold_vld_in;

   // Classify corners against the level
   always_comb begin
      v0 = bump(lower_left_sample);
      v1 = bump(lower_right_sample);
      v2 = bump(upper_left_sample);
      v3 = bump(upper_right_sample);
      lt[0] = v0 < cce_pkg::LEVEL;
      lt[1] = v1 < cce_pkg::LEVEL;
      lt[2] = v2 < cce_pkg::LEVEL;
      lt[3] = v3 < cce_pkg::LEVEL;
      all_below = &lt;
      col_ok = (column != '0) && (32'(column) < 32'(ROW_LENGTH));
      xr = column;
      xl = column - 1'b1;
      yb = {1'b0, row_index};
      yt = yb + 1'b1;
   end

   // Pick the segments of the cell in output order
   always_comb begin
      pd    = '0;
      ps    = '0;
      pe    = '0;
      opt0  = '0;
      opt1  = '0;
      have0 = 1'b0;
      have1 = 1'b0;
      seg0  = '0;
      seg1  = '0;
      n_seg = 2'd0;
      if (col_ok && !all_below) begin
         if (lt[1] && !lt[2]) begin
            pd = make_pt(xr, yb, 1'b1, 1'b1, 1'b1, 1'b0, v1, v2);
            ps = lt[0] ? make_pt(xl, yb, 1'b0, 1'b0, 1'b1, 1'b0, v0, v2)
                       : make_pt(xr, yb, 1'b1, 1'b1, 1'b0, 1'b0, v1, v0);
            pe = lt[3] ? make_pt(xr, yt, 1'b1, 1'b1, 1'b0, 1'b0, v3, v2)
                       : make_pt(xr, yb, 1'b0, 1'b0, 1'b1, 1'b0, v1, v3);
            seg0  = '{ps, pd, 1'b0};
            seg1  = '{pd, pe, 1'b1};
            n_seg = 2'd2;
         end else if (!lt[1] && lt[2]) begin
            pd = make_pt(xl, yt, 1'b1, 1'b0, 1'b1, 1'b1, v2, v1);
            ps = !lt[0] ? make_pt(xl, yt, 1'b0, 1'b0, 1'b1, 1'b1, v2, v0)
                        : make_pt(xl, yb, 1'b1, 1'b0, 1'b0, 1'b0, v0, v1);
            pe = !lt[3] ? make_pt(xl, yt, 1'b1, 1'b0, 1'b0, 1'b0, v2, v3)
                        : make_pt(xr, yt, 1'b0, 1'b0, 1'b1, 1'b1, v3, v1);
            seg0  = '{ps, pd, 1'b0};
            seg1  = '{pd, pe, 1'b1};
            n_seg = 2'd2;
         end else begin
            if (!lt[1]) begin
               have0 = lt[0];
               have1 = lt[3];
               opt0  = '{make_pt(xl, yb, 1'b1, 1'b0, 1'b0, 1'b0, v0, v1),
                         make_pt(xl, yb, 1'b0, 1'b0, 1'b1, 1'b0, v0, v2), 1'b0};
               opt1  = '{make_pt(xr, yt, 1'b1, 1'b1, 1'b0, 1'b0, v3, v2),
                         make_pt(xr, yt, 1'b0, 1'b0, 1'b1, 1'b1, v3, v1), 1'b0};
            end else begin
               have0 = !lt[0];
               have1 = !lt[3];
               opt0  = '{make_pt(xr, yb, 1'b1, 1'b1, 1'b0, 1'b0, v1, v0),
                         make_pt(xl, yt, 1'b0, 1'b0, 1'b1, 1'b1, v2, v0), 1'b0};
               opt1  = '{make_pt(xl, yt, 1'b1, 1'b0, 1'b0, 1'b0, v2, v3),
                         make_pt(xr, yb, 1'b0, 1'b0, 1'b1, 1'b0, v1, v3), 1'b0};
            end
            if (have0 && have1) begin
               seg0      = opt0;
               seg1      = opt1;
               seg1.last = 1'b1;
               n_seg     = 2'd2;
            end else if (have0) begin
               seg0      = opt0;
               seg0.last = 1'b1;
               n_seg     = 2'd1;
            end else if (have1) begin
               seg0      = opt1;
               seg0.last = 1'b1;
               n_seg     = 2'd1;
            end
         end
      end
   end

   // Push the first segment at accept, hold the second one until the queue has room
   always_comb begin
      req_full = hold_vld_ff || q_full;
      accept   = req_push && !req_full;
      if (hold_vld_ff) begin
         q_push      = !q_full;
         q_data      = hold_ff;
         hold_vld_in = q_full;
      end else begin
         q_push      = accept && (n_seg != 2'd0);
         q_data      = seg0;
         hold_vld_in = accept && (n_seg == 2'd2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= seg1;
      end
   end

endmodule

`default_nettype wire

[rtl/core/cce_div.sv]
// Pipelined fraction divider: floor(num * 2^16 / den), one quotient bit per stage.
`default_nettype none

module cce_div (
   input  wire logic                        clock,
   input  wire logic [cce_pkg::FRAC_W-1:0]  num,
   input  wire logic [cce_pkg::FRAC_W-1:0]  den,
   output logic [cce_pkg::FRAC_W-1:0]       quo
);

   logic [cce_pkg::FRAC_W-1:0] rem_ff [cce_pkg::DIV_STAGES];
   logic [cce_pkg::FRAC_W-1:0] den_ff [cce_pkg::DIV_STAGES];
   logic [cce_pkg::FRAC_W-1:0] quo_ff [cce_pkg::DIV_STAGES];

   for (genvar k = 0; k < cce_pkg::DIV_STAGES; k++) begin : g_stage
      logic [cce_pkg::FRAC_W-1:0] rem_prev, den_prev, quo_prev;
      logic [cce_pkg::FRAC_W-1:0] rem_in, quo_in;
      logic [cce_pkg::FRAC_W:0]   trial, diff;
      logic                       ge;

      if (k == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      // Shift in a zero, subtract when the divisor fits
      always_comb begin
         trial  = {rem_prev, 1'b0};
         diff   = trial - {1'b0, den_prev};
         ge     = trial >= {1'b0, den_prev};
         rem_in = ge ? diff[cce_pkg::FRAC_W-1:0] : trial[cce_pkg::FRAC_W-1:0];
         quo_in = {quo_prev[cce_pkg::FRAC_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         den_ff[k] <= den_prev;
         quo_ff[k] <= quo_in;
      end
   end

   assign quo = quo_ff[cce_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

[rtl/core/cce_back.sv]
// Arithmetic back end: divide, place, scale and saturate, then buffer results.
`default_nettype none

module cce_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_empty,
   input  cce_pkg::seg_type              q_data,
   output logic                          q_pop,
   input  cce_pkg::csr_type              csr,
   output logic                          rsp_empty,
   input  wire logic                     rsp_pop,
   output cce_pkg::rsp_type              rsp_data,
   output cce_pkg::back_status_type      status
);

   localparam int LAST = cce_pkg::DIV_STAGES - 1;

   // Grid position as unsigned Q.16, with an optional fraction added or taken off
   function automatic logic [cce_pkg::POS_W-1:0] pos_calc(
      input logic [cce_pkg::ROW_W:0]    ip,
      input logic                       on,
      input logic                       neg,
      input logic [cce_pkg::FRAC_W-1:0] f
   );
      logic [cce_pkg::POS_W-1:0] base;
      logic [cce_pkg::POS_W-1:0] fx;
      base = {ip, 16'b0};
      fx   = {17'b0, f};
      if (!on) begin
         return base;
      end
      return neg ? base - fx : base + fx;
   endfunction

   logic                         issue, pop_ok;
   logic [cce_pkg::CNT_W-1:0]    credits_ff, credits_in;
   logic [cce_pkg::FRAC_W-1:0]   fs, fe;
   cce_pkg::seg_type             sb_ff [cce_pkg::DIV_STAGES];
   logic [cce_pkg::DIV_STAGES-1:0] vld_ff;
   logic [cce_pkg::POS_W-1:0]    pos_ff [4];
   logic [cce_pkg::POS_W-1:0]    pos_in [4];
   logic                         vp_ff, vm_ff, vs_ff;
   logic                         lp_ff, lm_ff, ls_ff;
   logic [40:0]                  hi_ff [4];
   logic [39:0]                  lo_ff [4];
   logic [25:0]                  sc_ff [4];
   logic [cce_pkg::COORD_W-1:0]  crd [4];
   cce_pkg::rsp_type             out_mem_ff [cce_pkg::OUT_DEPTH];
   cce_pkg::rsp_type             out_in;
   logic [cce_pkg::OUT_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [cce_pkg::CNT_W-1:0]    cnt_ff, cnt_in;

   // Issue only when the result buffer has room for everything in flight
   assign issue  = !q_empty && (credits_ff < cce_pkg::CNT_W'(cce_pkg::OUT_DEPTH));
   assign q_pop  = issue;
   assign pop_ok = rsp_pop && (cnt_ff != '0);

   cce_div u_div_start (
      .clock (clock),
      .num   (q_data.start_pt.num),
      .den   (q_data.start_pt.den),
      .quo   (fs)
   );

   cce_div u_div_end (
      .clock (clock),
      .num   (q_data.end_pt.num),
      .den   (q_data.end_pt.den),
      .quo   (fe)
   );

   // Carry the segment alongside the dividers
   always_ff @(posedge clock) begin
      sb_ff[0] <= q_data;
      for (int k = 1; k < cce_pkg::DIV_STAGES; k++) begin
         sb_ff[k] <= sb_ff[k-1];
      end
   end

   // Place end points on the grid
   always_comb begin
      pos_in[0] = pos_calc({3'b0, sb_ff[LAST].start_pt.x_int}, sb_ff[LAST].start_pt.x_frac,
                           sb_ff[LAST].start_pt.x_neg, fs);
      pos_in[1] = pos_calc(sb_ff[LAST].start_pt.y_int, sb_ff[LAST].start_pt.y_frac,
                           sb_ff[LAST].start_pt.y_neg, fs);
      pos_in[2] = pos_calc({3'b0, sb_ff[LAST].end_pt.x_int}, sb_ff[LAST].end_pt.x_frac,
                           sb_ff[LAST].end_pt.x_neg, fe);
      pos_in[3] = pos_calc(sb_ff[LAST].end_pt.y_int, sb_ff[LAST].end_pt.y_frac,
                           sb_ff[LAST].end_pt.y_neg, fe);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         pos_ff[k] <= pos_in[k];
      end
      lp_ff <= sb_ff[LAST].last;
      lm_ff <= lp_ff;
      ls_ff <= lm_ff;
   end

   // Scale each coordinate: split multiply, then combine and truncate
   for (genvar k = 0; k < 4; k++) begin : g_coord
      logic [cce_pkg::SCALE_W-1:0] scale;
      logic [cce_pkg::COORD_W-1:0] origin;
      logic [41:0]                 sum;
      logic [26:0]                 shifted;

      assign scale  = (k % 2 == 1) ? csr.y_scale : csr.x_scale;
      assign origin = (k % 2 == 1) ? csr.y_origin : csr.x_origin;

      always_ff @(posedge clock) begin
         hi_ff[k] <= pos_ff[k][32:16] * scale;
         lo_ff[k] <= pos_ff[k][15:0] * scale;
      end

      assign sum = {1'b0, hi_ff[k]} + {18'b0, lo_ff[k][39:16]};

      always_ff @(posedge clock) begin
         sc_ff[k] <= sum[41:16];
      end

      // Add origin and saturate
      assign shifted = {1'b0, sc_ff[k]} + {11'b0, origin};
      assign crd[k]  = (|shifted[26:16]) ? '1 : shifted[15:0];
   end

   assign out_in = '{crd[0], crd[1], crd[2], crd[3], ls_ff};

   // Valid chain and buffer control
   always_comb begin
      credits_in = credits_ff + {{(cce_pkg::CNT_W-1){1'b0}}, issue}
                              - {{(cce_pkg::CNT_W-1){1'b0}}, pop_ok};
      cnt_in     = cnt_ff + {{(cce_pkg::CNT_W-1){1'b0}}, vs_ff}
                          - {{(cce_pkg::CNT_W-1){1'b0}}, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         vp_ff      <= 1'b0;
         vm_ff      <= 1'b0;
         vs_ff      <= 1'b0;
         credits_ff <= '0;
         cnt_ff     <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
      end else begin
         vld_ff     <= {vld_ff[cce_pkg::DIV_STAGES-2:0], issue};
         vp_ff      <= vld_ff[LAST];
         vm_ff      <= vp_ff;
         vs_ff      <= vm_ff;
         credits_ff <= credits_in;
         cnt_ff     <= cnt_in;
         if (vs_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // Store result
   always_ff @(posedge clock) begin
      if (vs_ff) begin
         out_mem_ff[wr_ptr_ff] <= out_in;
      end
   end

   assign rsp_data         = out_mem_ff[rd_ptr_ff];
   assign rsp_empty        = (cnt_ff == '0);
   assign status.credits   = credits_ff;
   assign status.out_count = cnt_ff;

endmodule

`default_nettype wire
